/* rtl/core/normal_ray_volume_thickness_macros.svh */
// assertion macros shared by the ray walk logic
// no dependencies
`ifndef NORMAL_RAY_VOLUME_THICKNESS_MACROS_SVH
`define NORMAL_RAY_VOLUME_THICKNESS_MACROS_SVH

// same-cycle implication, quiet during reset
`define NRVT_ASSERT_NOW(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("label failed");

// next-cycle implication, quiet during reset
`define NRVT_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("label failed");

`endif

/* rtl/core/nrvt_pkg.sv */
// shared types and constants for the normal ray thickness block
// no dependencies
`timescale 1ns / 1ps

package nrvt_pkg;

    localparam int VOL_DIM      = 256;
    localparam int ADDR_W       = 24;
    localparam int OCC_DEPTH    = 1 << ADDR_W;
    localparam int D_W          = 25;
    localparam logic [D_W-1:0] D_ONE = 25'd65536;
    localparam logic [8:0] DIM_MAX = 9'(VOL_DIM);
    localparam int COEF_N       = 12;
    localparam logic [3:0] OP_LAST = 4'd14;
    localparam logic [3:0] OP_COEF = 4'd3;

    typedef enum logic [1:0] {
        KIND_VOXEL   = 2'd0,
        KIND_COEF    = 2'd1,
        KIND_MEASURE = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    localparam logic [2:0] CFG_MAX_DEPTH = 3'd0;
    localparam logic [2:0] CFG_STEP      = 3'd1;
    localparam logic [2:0] CFG_COLS      = 3'd2;
    localparam logic [2:0] CFG_ROWS      = 3'd3;
    localparam logic [2:0] CFG_SLICES    = 3'd4;

    typedef struct packed {
        logic [1:0]         kind;
        logic [23:0]        voxel_address;
        logic [15:0]        voxel_label;
        logic [3:0]         coef_index;
        logic signed [31:0] coef_value;
        logic [19:0]        vertex_id;
        logic signed [19:0] pos_x;
        logic signed [19:0] pos_y;
        logic signed [19:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
    } cmd_t;

    typedef struct packed {
        logic [19:0] result_vertex;
        logic [23:0] thickness;
        logic        saturated;
    } result_t;

    typedef struct packed {
        logic [23:0] max_depth;
        logic [23:0] step;
        logic [8:0]  lim_col;
        logic [8:0]  lim_row;
        logic [8:0]  lim_slc;
    } walk_cfg_t;

    typedef struct packed {
        logic           done;
        logic [19:0]    vertex;
        logic [D_W-1:0] distance;
    } walk_stat_t;

endpackage

/* rtl/core/nrvt_mul.sv */
// shared registered signed multiplier used by every step of the walk
// no dependencies
`timescale 1ns / 1ps

module nrvt_mul (
    input  logic               clk,
    input  logic signed [31:0] a,
    input  logic signed [27:0] b,
    output logic signed [59:0] prod
);
    logic signed [59:0] prod_reg;
    logic signed [59:0] prod_next;

    assign prod_next = 60'(a * b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;
endmodule

/* rtl/core/nrvt_walk.sv */
// ray walk sequencer with occupancy memory and transform registers
// depends on nrvt_pkg, nrvt_mul and the assertion macro header
`timescale 1ns / 1ps
`include "normal_ray_volume_thickness_macros.svh"

module nrvt_walk (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  nrvt_pkg::cmd_t     cmd,
    input  nrvt_pkg::walk_cfg_t cfg,
    output logic               busy,
    output nrvt_pkg::walk_stat_t stat
);
    import nrvt_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_TEST = 8'b00000010,
        S_MUL  = 8'b00000100,
        S_ACC  = 8'b00001000,
        S_RND  = 8'b00010000,
        S_RD   = 8'b00100000,
        S_CHK  = 8'b01000000,
        S_DONE = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    logic [3:0]         op_reg, op_next;
    logic [D_W-1:0]     d_reg, d_next;
    logic signed [19:0] pos_reg [3];
    logic signed [15:0] nrm_reg [3];
    logic [19:0]        vid_reg;
    logic signed [27:0] p_reg [3];
    logic signed [63:0] acc_reg;
    logic [2:0]         inr_reg;
    logic [7:0]         crd_reg [3];
    logic               rd_reg;
    logic signed [31:0] coef_reg [COEF_N];
    logic               occ_mem [0:OCC_DEPTH-1];

    logic signed [31:0] mul_a;
    logic signed [27:0] mul_b;
    logic signed [59:0] prod;
    logic [3:0]         j;
    logic [1:0]         col;
    logic [1:0]         row;
    logic signed [43:0] p30;
    logic signed [63:0] rv;
    logic signed [31:0] vox;
    logic [8:0]         lim;
    logic [23:0]        step;
    logic               is_measure;

    assign is_measure = accept && (cmd.kind == KIND_MEASURE);
    assign j   = op_reg - OP_COEF;
    assign col = j[1:0];
    assign row = j[3:2];
    assign step = (cfg.step == 24'd0) ? 24'd1 : cfg.step;

    // operand select for the shared multiplier
    always_comb
    begin
        if (op_reg < OP_COEF)
        begin
            mul_a = 32'(nrm_reg[op_reg[1:0]]);
            mul_b = 28'({1'b0, d_reg});
        end
        else
        begin
            mul_a = coef_reg[j];
            case (col)
                2'd0:    mul_b = p_reg[0];
                2'd1:    mul_b = p_reg[1];
                2'd2:    mul_b = p_reg[2];
                default: mul_b = 28'sd65536;
            endcase
        end
    end

    nrvt_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign p30 = (44'(pos_reg[op_reg[1:0]]) <<< 20) - 44'(prod);

    // half away from zero: bias by one less for negative values, then floor
    assign rv  = acc_reg + (acc_reg[63] ? 64'sd2147483647 : 64'sd2147483648);
    assign vox = 32'(rv >>> 32);

    always_comb
    begin
        case (row)
            2'd0:    lim = cfg.lim_col;
            2'd1:    lim = cfg.lim_row;
            default: lim = cfg.lim_slc;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        d_next     = d_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (is_measure)
                begin
                    d_next     = D_ONE;
                    state_next = S_TEST;
                end
            end
            S_TEST:
            begin
                op_next    = 4'd0;
                state_next = (d_reg <= D_W'(cfg.max_depth)) ? S_MUL : S_DONE;
            end
            S_MUL:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (op_reg >= OP_COEF && col == 2'd3)
                begin
                    state_next = S_RND;
                end
                else
                begin
                    op_next    = op_reg + 4'd1;
                    state_next = S_MUL;
                end
            end
            S_RND:
            begin
                if (op_reg == OP_LAST)
                begin
                    state_next = S_RD;
                end
                else
                begin
                    op_next    = op_reg + 4'd1;
                    state_next = S_MUL;
                end
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if ((&inr_reg) && !rd_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    d_next     = d_reg + D_W'(step);
                    state_next = S_TEST;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= 4'd0;
            d_reg     <= D_ONE;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            d_reg     <= d_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && is_measure)
        begin
            pos_reg[0] <= cmd.pos_x;
            pos_reg[1] <= cmd.pos_y;
            pos_reg[2] <= cmd.pos_z;
            nrm_reg[0] <= cmd.norm_x;
            nrm_reg[1] <= cmd.norm_y;
            nrm_reg[2] <= cmd.norm_z;
            vid_reg    <= cmd.vertex_id;
        end
        if (state_reg == S_ACC)
        begin
            if (op_reg < OP_COEF)
            begin
                p_reg[op_reg[1:0]] <= 28'(p30 >>> 14);
            end
            else if (col == 2'd0)
            begin
                acc_reg <= 64'(prod);
            end
            else
            begin
                acc_reg <= acc_reg + 64'(prod);
            end
        end
        if (state_reg == S_RND)
        begin
            inr_reg[row] <= !vox[31] && (vox < $signed({23'd0, lim}));
            crd_reg[row] <= vox[7:0];
        end
    end

    // transform coefficients, loaded by transfer
    always_ff @(posedge clk)
    begin
        if (accept && cmd.kind == KIND_COEF && cmd.coef_index < 4'(COEF_N))
        begin
            coef_reg[cmd.coef_index] <= cmd.coef_value;
        end
    end

    // occupancy bits, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (accept && cmd.kind == KIND_VOXEL)
        begin
            occ_mem[cmd.voxel_address] <= |cmd.voxel_label;
        end
        rd_reg <= occ_mem[{crd_reg[2], crd_reg[1], crd_reg[0]}];
    end

    assign busy          = (state_reg != S_IDLE);
    assign stat.done     = (state_reg == S_DONE);
    assign stat.vertex   = vid_reg;
    assign stat.distance = d_reg;

    `NRVT_ASSERT_NEXT(a_measure_busy, clk, rst_n, is_measure && !busy, busy)
    `NRVT_ASSERT_NEXT(a_done_single, clk, rst_n, stat.done, !stat.done)
    `NRVT_ASSERT_NOW(a_dist_floor, clk, rst_n, busy, d_reg >= D_ONE)
endmodule

/* rtl/core/normal_ray_volume_thickness.sv */
// top level of the normal ray thickness block: config registers and result port
// depends on nrvt_pkg, nrvt_walk
`timescale 1ns / 1ps
// done is registered from the done state, which follows the check when a clear voxel stops
//   the walk and the depth test when it runs past max depth, so also when no step is taken
// a step is a depth test, 15 products on the shared multiplier, 3 rounds,
//   an occupancy read and a check; the next transfer can land while done is high
// voxel and coefficient transfers never raise busy; no receiver stall
// reset restores config defaults; occupancy and transform hold garbage until loaded

module normal_ray_volume_thickness (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  nrvt_pkg::cmd_t     cmd,
    output logic               done,
    output nrvt_pkg::result_t  result,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data
);
    import nrvt_pkg::*;

    // configuration registers
    logic [23:0] max_depth_reg;
    logic [23:0] step_reg;
    logic [8:0]  cols_reg;
    logic [8:0]  rows_reg;
    logic [8:0]  slcs_reg;

    logic        accept;
    walk_cfg_t   wcfg;
    walk_stat_t  stat;
    logic        done_reg;
    result_t     result_reg;
    result_t     result_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_depth_reg <= 24'd6291456;
            step_reg      <= 24'd655;
            cols_reg      <= 9'd256;
            rows_reg      <= 9'd256;
            slcs_reg      <= 9'd256;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_MAX_DEPTH: max_depth_reg <= cfg_data;
                CFG_STEP:      step_reg      <= cfg_data;
                CFG_COLS:      cols_reg      <= cfg_data[8:0];
                CFG_ROWS:      rows_reg      <= cfg_data[8:0];
                CFG_SLICES:    slcs_reg      <= cfg_data[8:0];
                default:       ;
            endcase
        end
    end

    // dimensions clip at the physical volume size
    assign wcfg.max_depth = max_depth_reg;
    assign wcfg.step      = step_reg;
    assign wcfg.lim_col   = (cols_reg < DIM_MAX) ? cols_reg : DIM_MAX;
    assign wcfg.lim_row   = (rows_reg < DIM_MAX) ? rows_reg : DIM_MAX;
    assign wcfg.lim_slc   = (slcs_reg < DIM_MAX) ? slcs_reg : DIM_MAX;

    // a transfer lands when start meets an idle block
    assign accept = start && !busy;

    nrvt_walk u_walk (
        .clk   (clk),
        .rst_n (rst_n),
        .accept(accept),
        .cmd   (cmd),
        .cfg   (wcfg),
        .busy  (busy),
        .stat  (stat)
    );

    // saturate distances that ran past the field range
    always_comb
    begin
        result_next.result_vertex = stat.vertex;
        result_next.saturated     = stat.distance[D_W-1];
        result_next.thickness     = stat.distance[D_W-1] ? 24'hFFFFFF : stat.distance[23:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= stat.done;
        end
    end

    // output register holds the last result
    always_ff @(posedge clk)
    begin
        if (stat.done)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;
endmodule

/* verif/testbench.sv */
// testbench for normal_ray_volume_thickness: ray walk thickness checked against a local predictor
// depends on nrvt_pkg and the normal_ray_volume_thickness rtl
`timescale 1ns / 1ps

module testbench;
    import nrvt_pkg::*;

    localparam int STALL_LIMIT = 20000;   // cycles with no transfer before giving up
    localparam int SETTLE      = 12;      // cycles to let writes retire

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    cmd_t        cmd;
    logic        done;
    result_t     result;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [23:0] cfg_data;

    normal_ray_volume_thickness dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // commands waiting for the driver, thicknesses waiting for the block
    cmd_t    cmd_backlog[$];
    result_t thickness_due[$];

    // local copy of the block state: written voxels only, the transform and the config registers
    bit          occ_bits[int unsigned];
    longint      coef[12];
    logic [23:0] depth_limit;
    logic [23:0] step_len;
    logic [8:0]  cols_reg;
    logic [8:0]  rows_reg;
    logic [8:0]  slcs_reg;

    int  errors;
    int  stall_cycles;
    bit  took;       // last rising edge moved a command
    bit  quiet;      // no idling in the closing stretch
    int  gap;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // q.32 to integer, half away from zero
    function automatic longint round_q32(input longint v);
        if (v >= 0)
            return (v + 64'sd2147483648) >>> 32;
        return -((-v + 64'sd2147483648) >>> 32);
    endfunction

    function automatic longint dim_of(input logic [8:0] r);
        return (r < 9'd256) ? longint'(r) : 64'sd256;
    endfunction

    // walk the ray; stops early and flags the address of the first voxel it reaches that was never loaded
    function automatic void walk_thickness(input cmd_t c, output longint d,
                                           output bit miss, output int unsigned miss_addr);
        longint pos[3];
        longint nrm[3];
        longint p[3];
        longint vox[3];
        longint acc;
        longint stride;
        int unsigned addr;
        bit     in_box;
        pos[0] = longint'($signed(c.pos_x)) * 1048576;
        pos[1] = longint'($signed(c.pos_y)) * 1048576;
        pos[2] = longint'($signed(c.pos_z)) * 1048576;
        nrm[0] = longint'($signed(c.norm_x));
        nrm[1] = longint'($signed(c.norm_y));
        nrm[2] = longint'($signed(c.norm_z));
        stride = (step_len == 24'd0) ? 1 : longint'(step_len);
        d = 65536;
        miss = 1'b0;
        miss_addr = 0;
        while (d <= longint'(depth_limit))
        begin
            for (int k = 0; k < 3; k++)
                p[k] = (pos[k] - d * nrm[k]) >>> 14;
            for (int k = 0; k < 3; k++)
            begin
                acc = coef[4*k] * p[0] + coef[4*k+1] * p[1] + coef[4*k+2] * p[2]
                    + coef[4*k+3] * 65536;
                vox[k] = round_q32(acc);
            end
            in_box = vox[0] >= 0 && vox[0] < dim_of(cols_reg) &&
                     vox[1] >= 0 && vox[1] < dim_of(rows_reg) &&
                     vox[2] >= 0 && vox[2] < dim_of(slcs_reg);
            if (in_box)
            begin
                addr = int'(vox[2]) * 65536 + int'(vox[1]) * 256 + int'(vox[0]);
                if (!occ_bits.exists(addr))
                begin
                    miss = 1'b1;
                    miss_addr = addr;
                    return;
                end
                if (!occ_bits[addr])
                    break;
            end
            d += stride;
        end
    endfunction

    // queue a command and track what it does to the local state
    task automatic push_cmd(input cmd_t c);
        longint      d;
        bit          miss;
        int unsigned addr;
        cmd_t        fill;
        result_t     r;
        if (c.kind == KIND_MEASURE)
        begin
            // load every voxel the walk would touch before it is ever read
            walk_thickness(c, d, miss, addr);
            while (miss)
            begin
                fill = cmd_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                               $urandom});
                fill.kind = KIND_VOXEL;
                fill.voxel_address = addr[23:0];
                if ($urandom_range(0, 9) < 3)
                    fill.voxel_label = 16'd0;
                else if (fill.voxel_label == 16'd0)
                    fill.voxel_label = 16'd1;
                push_cmd(fill);
                walk_thickness(c, d, miss, addr);
            end
            r.result_vertex = c.vertex_id;
            r.thickness = (d > 64'sd16777215) ? 24'hFFFFFF : d[23:0];
            r.saturated = (d > 64'sd16777215);
            thickness_due.push_back(r);
        end
        else if (c.kind == KIND_VOXEL)
            occ_bits[{8'd0, c.voxel_address}] = (c.voxel_label != 16'd0);
        else if (c.kind == KIND_COEF && c.coef_index < 4'd12)
            coef[c.coef_index] = longint'($signed(c.coef_value));
        cmd_backlog.push_back(c);
    endtask

    function automatic cmd_t noise_cmd(input kind_t k);
        cmd_t c;
        c = cmd_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        c.kind = k;
        return c;
    endfunction

    // a vertex within the valid box, far faces included, with each normal component in -1..1
    function automatic cmd_t inside_measure();
        cmd_t c;
        c = noise_cmd(KIND_MEASURE);
        c.pos_x = 20'($urandom_range(0, 1024 * int'(dim_of(cols_reg))));
        c.pos_y = 20'($urandom_range(0, 1024 * int'(dim_of(rows_reg))));
        c.pos_z = 20'($urandom_range(0, 1024 * int'(dim_of(slcs_reg))));
        c.norm_x = 16'($urandom_range(0, 32768) - 16384);
        c.norm_y = 16'($urandom_range(0, 32768) - 16384);
        c.norm_z = 16'($urandom_range(0, 32768) - 16384);
        return c;
    endfunction

    task automatic coef_write(input int idx, input longint v);
        cmd_t c;
        c = noise_cmd(KIND_COEF);
        c.coef_index = 4'(idx);
        c.coef_value = 32'(v);
        push_cmd(c);
    endtask

    // voxel space equals millimetre space, one voxel per mm
    task automatic load_identity();
        for (int i = 0; i < 12; i++)
            coef_write(i, (i == 0 || i == 5 || i == 10) ? 65536 : 0);
    endtask

    task automatic cfg_put(input logic [2:0] idx, input logic [23:0] val);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        case (idx)
            CFG_MAX_DEPTH: depth_limit = val;
            CFG_STEP:      step_len = val;
            CFG_COLS:      cols_reg = val[8:0];
            CFG_ROWS:      rows_reg = val[8:0];
            CFG_SLICES:    slcs_reg = val[8:0];
            default:       ;
        endcase
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    task automatic set_walk(input logic [23:0] depth, input logic [23:0] stride,
                            input int c, input int r, input int s);
        cfg_put(CFG_MAX_DEPTH, depth);
        cfg_put(CFG_STEP, stride);
        cfg_put(CFG_COLS, 24'(c));
        cfg_put(CFG_ROWS, 24'(r));
        cfg_put(CFG_SLICES, 24'(s));
    endtask

    // registers move only once the block has gone quiet
    task automatic drain();
        while (cmd_backlog.size() != 0 || start || thickness_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // driver: one decision per falling edge, held until the transfer happens
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (start && !took)
            ;
        else if (gap > 0)
        begin
            gap = gap - 1;
            start <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(0, 2);
            start <= 1'b0;
        end
        else if (cmd_backlog.size() != 0)
        begin
            cmd <= cmd_backlog.pop_front();
            start <= 1'b1;
        end
        else
            start <= 1'b0;
    end

    // monitor: results are checked in order whenever done is raised
    always @(posedge clk)
    begin
        result_t want;
        took <= rst_n && start && !busy;
        if (rst_n && done)
        begin
            if (thickness_due.size() == 0)
            begin
                $error("thickness result with none expected: vertex %0d", result.result_vertex);
                errors++;
            end
            else
            begin
                want = thickness_due.pop_front();
                if (result.result_vertex !== want.result_vertex)
                begin
                    $error("result_vertex expected %0d got %0d",
                           want.result_vertex, result.result_vertex);
                    errors++;
                end
                if (result.thickness !== want.thickness)
                begin
                    $error("thickness expected %0d got %0d", want.thickness, result.thickness);
                    errors++;
                end
                if (result.saturated !== want.saturated)
                begin
                    $error("saturated expected %0d got %0d", want.saturated, result.saturated);
                    errors++;
                end
            end
        end
        // watchdog on transfers in either direction
        if ((rst_n && start && !busy) || done)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial
    begin
        cmd_t        c;
        int          pick;
        logic [23:0] depth;
        logic [23:0] stride;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_write = 1'b0;
        cfg_index = CFG_MAX_DEPTH;
        cfg_data = '0;
        errors = 0;
        stall_cycles = 0;
        took = 1'b0;
        quiet = 1'b0;
        gap = 0;
        depth_limit = 24'd6291456;
        step_len = 24'd655;
        cols_reg = 9'd256;
        rows_reg = 9'd256;
        slcs_reg = 9'd256;
        for (int i = 0; i < 12; i++)
            coef[i] = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: short walk in a small box, field extremes, ignored kinds
        set_walk(24'd262144, 24'd32768, 4, 4, 4);
        load_identity();
        coef_write(15, 32'h7FFFFFFF);        // index past the table, dropped
        push_cmd(noise_cmd(KIND_NONE));      // unknown kind, no result
        c = inside_measure();
        c.vertex_id = 20'd0;
        push_cmd(c);
        c = inside_measure();
        c.vertex_id = 20'hFFFFF;
        push_cmd(c);
        c = noise_cmd(KIND_MEASURE);
        c.pos_x = 20'h7FFFF; c.pos_y = 20'h80000; c.pos_z = 20'h7FFFF;
        c.norm_x = 16'h8000; c.norm_y = 16'h7FFF; c.norm_z = 16'h8000;
        push_cmd(c);
        c.pos_x = 20'h80000; c.pos_y = 20'h7FFFF; c.pos_z = 20'h80000;
        c.norm_x = 16'h7FFF; c.norm_y = 16'h8000; c.norm_z = 16'h7FFF;
        push_cmd(c);
        c = noise_cmd(KIND_VOXEL);
        c.voxel_address = 24'hFFFFFF;
        c.voxel_label = 16'hFFFF;
        push_cmd(c);
        drain();

        // max depth below 1 mm: no step at all
        set_walk(24'd0, 24'd1, 256, 256, 256);
        push_cmd(inside_measure());
        push_cmd(noise_cmd(KIND_MEASURE));
        drain();

        // one giant step runs past the field and saturates unless the first voxel is clear
        set_walk(24'hFFFFFF, 24'hFFFFFF, 1, 1, 1);
        push_cmd(inside_measure());
        push_cmd(noise_cmd(KIND_MEASURE));
        drain();

        // random phases; the last one runs without idling
        for (int ph = 0; ph < 13; ph++)
        begin
            depth = 24'($urandom_range(0, 20 * 65536));
            stride = 24'($urandom_range(depth / 30 + 1, depth / 4 + 2));
            if (ph == 4)
                set_walk(depth, stride, 256, 256, 256);
            else if (ph == 8)
                set_walk(depth, stride, 1, 1, 1);
            else
                set_walk(depth, stride, $urandom_range(1, 16), $urandom_range(1, 16),
                         $urandom_range(1, 16));
            if (ph == 12)
                quiet = 1'b1;
            load_identity();
            for (int n = 0; n < 20; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                    push_cmd(inside_measure());
                else if (pick < 65)
                    push_cmd(noise_cmd(KIND_MEASURE));
                else if (pick < 82)
                begin
                    c = noise_cmd(KIND_VOXEL);
                    c.voxel_address = 24'($urandom_range(0, int'(dim_of(slcs_reg)) - 1) * 65536
                                    + $urandom_range(0, int'(dim_of(rows_reg)) - 1) * 256
                                    + $urandom_range(0, int'(dim_of(cols_reg)) - 1));
                    if ($urandom_range(0, 2) == 0)
                        c.voxel_label = 16'd0;
                    push_cmd(c);
                end
                else if (pick < 88)
                    push_cmd(noise_cmd(KIND_VOXEL));
                else if (pick < 92)
                    push_cmd(noise_cmd(KIND_COEF));   // wild coefficient, any index
                else if (pick < 95)
                    push_cmd(noise_cmd(KIND_NONE));
                else
                    load_identity();
            end
            drain();
        end

        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

/* normal_ray_volume_thickness.f */
+incdir+rtl/core
rtl/core/nrvt_pkg.sv
rtl/core/nrvt_mul.sv
rtl/core/nrvt_walk.sv
rtl/core/normal_ray_volume_thickness.sv
verif/testbench.sv
